// ===== hw/rtl/lsb_stego_bit_extractor_unit_assert.svh =====
// Assertion helpers for the LSB extractor. Define ASSERT_OFF to drop them.
`ifndef LSB_STEGO_BIT_EXTRACTOR_UNIT_ASSERT_SVH
`define LSB_STEGO_BIT_EXTRACTOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define LSBX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsbx assertion failed");

`define LSBX_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`else

`define LSBX_ASSERT(lbl, prop)
`define LSBX_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/lsbx_pkg.sv =====
package lsbx_pkg;

  localparam int unsigned BYTE_BITS = 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BITS_CHAN0   = 3'd0,
    REG_BITS_CHAN1   = 3'd1,
    REG_BITS_CHAN2   = 3'd2,
    REG_PIXEL_STRIDE = 3'd3,
    REG_TOTAL_BYTES  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]  bits_chan0;
    logic [3:0]  bits_chan1;
    logic [3:0]  bits_chan2;
    logic [15:0] pixel_stride;
    logic [31:0] total_bytes;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] hidden_byte;
    logic       is_last;
  } pack_res_t;

  // mask of the n low bits of a byte, n saturating at eight
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [15:0] ones;
    ones = (16'd1 << n) - 16'd1;
    return (n >= 4'(BYTE_BITS)) ? 8'hFF : ones[7:0];
  endfunction

endpackage

// ===== hw/rtl/lsb_stego_bit_extractor_unit.sv =====
// LSB steganography bit extractor.
// Slave stream: one cover channel byte per request, pixels in B,G,R order.
// Master stream: recovered hidden bytes, MSB first; tlast marks the byte
// that brings the count up to total_bytes. After that all input is
// swallowed without output until the count or total_bytes changes.
// Config channel: index/data writes, index 0..4 = bits_chan0, bits_chan1,
// bits_chan2, pixel_stride, total_bytes; other indexes are ignored.
// Always ready; write only while the stream is idle.
// Path: a byte accepted into the input register is processed, and its
// result (if any) is loaded into the output register, which drives
// m_axis_tvalid; a full output register can hold it back.
// Throughput: one cover byte per cycle while results drain, set by the
// single input register feeding the packing logic and one output register.
// Receiver stall: a byte that produces no result still drains; one that
// produces a result waits in the input register until the output
// register frees, while the output register holds its byte steady.
// Reset: bit counts return to 1, stride and total to 0 (no output until
// total_bytes is written); packing state and byte count clear.
`include "lsb_stego_bit_extractor_unit_assert.svh"

module lsb_stego_bit_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cover byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cover_byte
  // hidden byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] hidden_byte
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import lsbx_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  logic [7:0] in_byte_q;
  logic      out_valid_q;
  logic [7:0] out_byte_q;
  logic      out_last_q;
  logic      s_acc, advance, out_free;
  pack_res_t pack_res;

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_chan0   <= 4'd1;
      cfg_q.bits_chan1   <= 4'd1;
      cfg_q.bits_chan2   <= 4'd1;
      cfg_q.pixel_stride <= 16'd0;
      cfg_q.total_bytes  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BITS_CHAN0:   cfg_q.bits_chan0   <= cfg_data_i[3:0];
        REG_BITS_CHAN1:   cfg_q.bits_chan1   <= cfg_data_i[3:0];
        REG_BITS_CHAN2:   cfg_q.bits_chan2   <= cfg_data_i[3:0];
        REG_PIXEL_STRIDE: cfg_q.pixel_stride <= cfg_data_i[15:0];
        REG_TOTAL_BYTES:  cfg_q.total_bytes  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage moves on unless it has a byte for a full output register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!pack_res.emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_acc) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  lsbx_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .src_i  (in_byte_q),
    .step_i (advance),
    .res_o  (pack_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && pack_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pack_res.emit) begin
      out_byte_q <= pack_res.hidden_byte;
      out_last_q <= pack_res.is_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // a pending result is never overwritten before the receiver takes it
  `LSBX_ASSERT_MSG(a_no_overwrite,
    (m_axis_tvalid && !m_axis_tready) |-> !(advance && pack_res.emit),
    "lsbx: pending hidden byte overwritten")
  // a produced byte always shows up on the master side
  `LSBX_ASSERT(a_emit_shows, (advance && pack_res.emit) |=> m_axis_tvalid)
  // a stalled input byte stays put
  `LSBX_ASSERT(a_in_hold, (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))

endmodule

// ===== hw/rtl/lsbx_pack.sv =====
module lsbx_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsbx_pkg::cfg_t    cfg_i,
  input  logic [7:0]        src_i,
  input  logic              step_i,
  output lsbx_pkg::pack_res_t res_o
);
  import lsbx_pkg::*;

  logic [1:0]  channel_pos_q, channel_pos_d;
  logic [17:0] skip_left_q, skip_left_d;
  logic [7:0]  partial_q, partial_d;
  logic [2:0]  held_q, held_d;
  logic [31:0] bytes_done_q, bytes_done_d;

  logic        done;
  logic [3:0]  nsel, n, sum, room;
  logic [2:0]  rest;
  logic [15:0] sh_room, sh_n;
  logic [7:0]  merged;
  logic        emit, last;
  logic [7:0]  result;

  always_comb begin
    done = (bytes_done_q == cfg_i.total_bytes);
    case (channel_pos_q)
      2'd1:    nsel = cfg_i.bits_chan1;
      2'd2:    nsel = cfg_i.bits_chan2;
      default: nsel = cfg_i.bits_chan0;
    endcase
    n       = (nsel > 4'(BYTE_BITS)) ? 4'(BYTE_BITS) : nsel;
    sum     = {1'b0, held_q} + n;
    rest    = 3'(sum - 4'(BYTE_BITS));
    room    = 4'(BYTE_BITS) - {1'b0, held_q};
    sh_room = {8'd0, partial_q} << room;
    sh_n    = {8'd0, partial_q} << n;
    merged  = sh_n[7:0] | (src_i & low_mask(n));

    channel_pos_d = channel_pos_q;
    skip_left_d   = skip_left_q;
    partial_d     = partial_q;
    held_d        = held_q;
    bytes_done_d  = bytes_done_q;
    emit          = 1'b0;
    last          = 1'b0;
    result        = 8'd0;

    if (!done) begin
      if (skip_left_q != 18'd0) begin
        skip_left_d = skip_left_q - 18'd1;
      end else begin
        if (n != 4'd0) begin
          if (sum > 4'(BYTE_BITS)) begin
            // chunk straddles the byte boundary
            result    = sh_room[7:0] | ((src_i >> rest) & low_mask(room));
            emit      = 1'b1;
            partial_d = src_i & low_mask({1'b0, rest});
            held_d    = rest;
          end else if (sum == 4'(BYTE_BITS)) begin
            result    = merged;
            emit      = 1'b1;
            partial_d = 8'd0;
            held_d    = 3'd0;
          end else begin
            partial_d = merged;
            held_d    = sum[2:0];
          end
        end
        if (channel_pos_q >= 2'd2) begin
          channel_pos_d = 2'd0;
          skip_left_d   = {2'b00, cfg_i.pixel_stride} + {1'b0, cfg_i.pixel_stride, 1'b0};
        end else begin
          channel_pos_d = channel_pos_q + 2'd1;
        end
        if (emit) begin
          bytes_done_d = bytes_done_q + 32'd1;
          last         = (bytes_done_d == cfg_i.total_bytes);
          if (last) begin
            // leftover bits after the final byte are dropped
            partial_d = 8'd0;
            held_d    = 3'd0;
          end
        end
      end
    end

    res_o.emit        = emit;
    res_o.hidden_byte = result;
    res_o.is_last     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_pos_q <= 2'd0;
      skip_left_q   <= 18'd0;
      partial_q     <= 8'd0;
      held_q        <= 3'd0;
      bytes_done_q  <= 32'd0;
    end else if (step_i) begin
      channel_pos_q <= channel_pos_d;
      skip_left_q   <= skip_left_d;
      partial_q     <= partial_d;
      held_q        <= held_d;
      bytes_done_q  <= bytes_done_d;
    end
  end

endmodule
